// File: design/nrrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrrd_pkg
// Shared types and constants of the reader response deframer.
// ----------------------------------------------------------------------------
package nrrd_pkg;

	localparam int unsigned LimitW = 9;
	localparam logic [LimitW-1:0] LIMIT_RESET = 9'd257;

	localparam logic [7:0] PRE_BYTE   = 8'h00;
	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] POST_BYTE  = 8'h00;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BADSTART  = 3'd1;
	localparam logic [2:0] ST_BADLCS    = 3'd2;
	localparam logic [2:0] ST_TOOLARGE  = 3'd3;
	localparam logic [2:0] ST_BADPOST   = 3'd4;
	localparam logic [2:0] ST_BADDCS    = 3'd5;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic       frame_done;
		logic [2:0] frame_status;
		logic [7:0] frame_length;
	} res_t;

endpackage
`default_nettype wire

// File: design/nrrd_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrrd_in_stage
// Input register: captures one received item and holds it until the parser
// advances.
// ----------------------------------------------------------------------------
module nrrd_in_stage
	import nrrd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
	input  wire logic [0:0] s_tuser,   // [0] frame_start
	input  wire logic     adv,
	output logic          valid_s1,
	output in_item_t      item_s1
);

	logic take;

	assign s_tready = !valid_s1 || adv;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.rx_byte     <= s_tdata;
			item_s1.frame_start <= s_tuser[0];
		end
	end

	a_adv_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> valid_s1)
		else $error("parser advanced with no item held");

endmodule
`default_nettype wire

// File: design/nrrd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrrd_parser
// Frame state machine: header checks, payload pass-through, checksums.
// ----------------------------------------------------------------------------
module nrrd_parser
	import nrrd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [LimitW-1:0] cfg_wdata,
	input  wire logic              adv,
	input  wire in_item_t          item_s1,
	output logic                   res_valid,
	output res_t                   res
);

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_PRE0  = 4'd1;
	localparam logic [3:0] PH_PRE1  = 4'd2;
	localparam logic [3:0] PH_START = 4'd3;
	localparam logic [3:0] PH_LEN   = 4'd4;
	localparam logic [3:0] PH_LCS   = 4'd5;
	localparam logic [3:0] PH_DATA  = 4'd6;
	localparam logic [3:0] PH_DCS   = 4'd7;
	localparam logic [3:0] PH_POST  = 4'd8;

	logic [LimitW-1:0] limit_q;
	logic [3:0]        phase_q, phase_d;
	logic [7:0]        len_q, len_d;
	logic [7:0]        left_q, left_d;
	logic [7:0]        sum_q, sum_d;
	logic [7:0]        dcs_q, dcs_d;
	logic [7:0]        b;
	logic [7:0]        lcs_sum, dcs_sum, left_dec;
	logic [LimitW:0]   need;
	logic              done;
	logic [2:0]        status;

	assign b        = item_s1.rx_byte;
	assign lcs_sum  = len_q + b;
	assign dcs_sum  = sum_q + dcs_q;
	assign left_dec = left_q - 8'd1;
	assign need     = {{(LimitW + 1 - 8){1'b0}}, len_q} + (LimitW + 1)'(2);

	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		left_d    = left_q;
		sum_d     = sum_q;
		dcs_d     = dcs_q;
		done      = 1'b0;
		status    = ST_OK;
		res_valid = 1'b0;
		res       = '0;
		if (item_s1.frame_start) begin
			phase_d = PH_PRE0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				PH_PRE0: begin
					if (b != PRE_BYTE) begin
						done   = 1'b1;
						status = ST_BADSTART;
					end else begin
						phase_d = PH_PRE1;
					end
				end
				PH_PRE1: begin
					if (b != PRE_BYTE) begin
						done   = 1'b1;
						status = ST_BADSTART;
					end else begin
						phase_d = PH_START;
					end
				end
				PH_START: begin
					if (b != START_BYTE) begin
						done   = 1'b1;
						status = ST_BADSTART;
					end else begin
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					len_d   = b;
					phase_d = PH_LCS;
				end
				PH_LCS: begin
					if (lcs_sum != 8'd0) begin
						done   = 1'b1;
						status = ST_BADLCS;
					end else if (need > {1'b0, limit_q}) begin
						done   = 1'b1;
						status = ST_TOOLARGE;
					end else begin
						sum_d   = 8'd0;
						left_d  = len_q;
						phase_d = (len_q == 8'd0) ? PH_DCS : PH_DATA;
					end
				end
				PH_DATA: begin
					sum_d          = sum_q + b;
					left_d         = left_dec;
					if (left_dec == 8'd0) begin
						phase_d = PH_DCS;
					end
					res_valid      = 1'b1;
					res.data_byte  = b;
					res.data_valid = 1'b1;
				end
				PH_DCS: begin
					dcs_d   = b;
					phase_d = PH_POST;
				end
				PH_POST: begin
					done = 1'b1;
					if (b != POST_BYTE) begin
						status = ST_BADPOST;
					end else if (dcs_sum != 8'd0) begin
						status = ST_BADDCS;
					end else begin
						status = ST_OK;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
			if (done) begin
				phase_d            = PH_IDLE;
				res_valid          = 1'b1;
				res.frame_done     = 1'b1;
				res.frame_status   = status;
				res.frame_length   = (status == ST_OK) ? len_q : 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wen) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q   <= 8'd0;
			left_q  <= 8'd0;
			sum_q   <= 8'd0;
			dcs_q   <= 8'd0;
		end else if (adv) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
			dcs_q   <= dcs_d;
		end
	end

	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.frame_start |=> phase_q == PH_PRE0)
		else $error("start mark did not restart the frame");

	a_last_payload: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !item_s1.frame_start && phase_q == PH_DATA && left_q == 8'd1
		|=> phase_q == PH_DCS)
		else $error("payload count did not end at DCS");

	a_payload_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.data_valid |-> phase_q == PH_DATA && !res.frame_done)
		else $error("payload item outside the payload phase");

endmodule
`default_nettype wire

// File: design/nrrd_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrrd_out_reg
// Result register on the master side; loads a new item while empty or in the
// cycle the held one is taken.
// ----------------------------------------------------------------------------
module nrrd_out_reg
	import nrrd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load,
	input  wire res_t   res,
	output logic        can_load,
	output logic        m_tvalid,
	input  wire logic   m_tready,
	output logic [15:0] m_tdata,   // [7:0] data_byte, [15:8] frame_length
	output logic [3:0]  m_tuser,   // [0] data_valid, [3:1] frame_status
	output logic        m_tlast    // frame_done
);

	res_t res_q;
	logic valid_q;

	assign can_load = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {res_q.frame_length, res_q.data_byte};
	assign m_tuser  = {res_q.frame_status, res_q.data_valid};
	assign m_tlast  = res_q.frame_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !valid_q || m_tready)
		else $error("result register overwritten while held");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> res_q.data_valid != res_q.frame_done)
		else $error("result is neither payload nor end of frame");

endmodule
`default_nettype wire

// File: design/nfc_reader_response_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_reader_response_deframer
// Deframes one reader response: preamble and start code, LEN/LCS, payload
// pass-through, DCS and postamble checks.
// ----------------------------------------------------------------------------
// One received byte per item, one cycle per item while results are taken: a
// byte goes into the input register, the frame state machine handles it there
// and its result (a payload byte or the end-of-frame status) lands in the
// output register, so bytes flow back to back. A held result stalls input
// only when the output is not taken. Payload bytes are passed as they arrive;
// on any error status the consumer drops what it got of that frame. After an
// end of frame the block waits for a byte with the start mark in tuser; a
// start mark in mid-frame drops the frame silently.
// ----------------------------------------------------------------------------
module nfc_reader_response_deframer
	import nrrd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [LimitW-1:0] cfg_wdata,  // buffer_limit
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,    // [7:0] rx_byte
	input  wire logic [0:0]        s_tuser,    // [0] frame_start
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [15:0]            m_tdata,    // [7:0] data_byte, [15:8] frame_length
	output logic [3:0]             m_tuser,    // [0] data_valid, [3:1] frame_status
	output logic                   m_tlast     // frame_done
);

	in_item_t item_s1;
	res_t     res;
	logic     valid_s1;
	logic     can_load;
	logic     adv;
	logic     res_valid;

	// every item takes the output slot's turn, whether it yields a result or not
	assign adv = valid_s1 && can_load;

	nrrd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	nrrd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.adv       (adv),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	nrrd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv && res_valid),
		.res      (res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// File: tb/nfc_reader_response_deframer_tb.sv
// ----------------------------------------------------------------------------
// nfc_reader_response_deframer_tb
// Self-checking bench for the reader response deframer. A short table of
// hand-built frames, then random frames (some well formed, some with broken
// headers, checksums or postambles, some cut short by a new start mark) are
// streamed in, under several buffer limits and back-pressure mixes. Every
// result item is checked against the table's expected item or an in-bench frame predictor.
// ----------------------------------------------------------------------------
module nfc_reader_response_deframer_tb;
	import nrrd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 6;

	typedef enum logic [3:0] {
		F_IDLE, F_PRE0, F_PRE1, F_START, F_LEN, F_LCS, F_DATA, F_DCS, F_POST
	} frame_phase_t;

	typedef struct {
		logic [7:0] b;
		logic       st;
		bit         typed;
		res_t       want;
	} row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wen = 1'b0;
	logic [LimitW-1:0] cfg_wdata = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;   // [7:0] rx_byte
	logic [0:0]        s_tuser = '0;   // [0] frame_start
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;        // [7:0] data_byte, [15:8] frame_length
	logic [3:0]        m_tuser;        // [0] data_valid, [3:1] frame_status
	logic              m_tlast;        // frame_done

	// predictor state
	frame_phase_t      fr_phase = F_IDLE;
	logic [7:0]        fr_len = '0;
	logic [7:0]        fr_left = '0;
	logic [7:0]        fr_sum = '0;
	logic [7:0]        fr_dcs = '0;
	logic [LimitW-1:0] buf_limit = LIMIT_RESET;

	res_t pending [$];
	int   errors = 0;
	int   cycles = 0;
	int   sent = 0;
	int   send_idle = 0;
	int   recv_idle = 0;

	// hand-built frames; typed rows carry their end-of-frame status
	row_t script [26] = '{
		'{8'h5A, 1'b0, 1'b0, '0},                                   // byte while idle
		'{8'h00, 1'b1, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hFE, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BADSTART, 8'h00}},
		'{8'hFF, 1'b1, 1'b0, '0},                                   // zero length frame
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK, 8'h00}},
		'{8'h00, 1'b1, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b0, '0},                                   // restart mid-frame
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h02, 1'b0, 1'b0, '0},                                   // DCS wrong too
		'{8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BADPOST, 8'h00}},
		'{8'h00, 1'b1, 1'b0, '0},
		'{8'h7F, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BADSTART, 8'h00}}
	};

	nfc_reader_response_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic res_t frame_end(input logic [2:0] status);
		res_t r;
		r = '0;
		r.frame_done = 1'b1;
		r.frame_status = status;
		if (status == ST_OK) begin
			r.frame_length = fr_len;
		end
		fr_phase = F_IDLE;
		return r;
	endfunction

	// advances the frame state by one byte; returns 1 when a result item is due
	function automatic bit deframe_step(input logic [7:0] b, input logic st, output res_t r);
		r = '0;
		if (st) begin
			fr_phase = F_PRE0;
			return 1'b0;
		end
		case (fr_phase)
			F_PRE0: begin
				if (b != PRE_BYTE) begin
					r = frame_end(ST_BADSTART);
					return 1'b1;
				end
				fr_phase = F_PRE1;
			end
			F_PRE1: begin
				if (b != PRE_BYTE) begin
					r = frame_end(ST_BADSTART);
					return 1'b1;
				end
				fr_phase = F_START;
			end
			F_START: begin
				if (b != START_BYTE) begin
					r = frame_end(ST_BADSTART);
					return 1'b1;
				end
				fr_phase = F_LEN;
			end
			F_LEN: begin
				fr_len = b;
				fr_phase = F_LCS;
			end
			F_LCS: begin
				if (8'(fr_len + b) != 8'h00) begin
					r = frame_end(ST_BADLCS);
					return 1'b1;
				end
				if (10'(fr_len) + 10'd2 > 10'(buf_limit)) begin
					r = frame_end(ST_TOOLARGE);
					return 1'b1;
				end
				fr_sum = '0;
				fr_left = fr_len;
				fr_phase = (fr_len == 8'd0) ? F_DCS : F_DATA;
			end
			F_DATA: begin
				fr_sum = fr_sum + b;
				fr_left = fr_left - 8'd1;
				if (fr_left == 8'd0) begin
					fr_phase = F_DCS;
				end
				r.data_byte = b;
				r.data_valid = 1'b1;
				return 1'b1;
			end
			F_DCS: begin
				fr_dcs = b;
				fr_phase = F_POST;
			end
			F_POST: begin
				if (b != POST_BYTE) begin
					r = frame_end(ST_BADPOST);
				end else if (8'(fr_sum + fr_dcs) != 8'h00) begin
					r = frame_end(ST_BADDCS);
				end else begin
					r = frame_end(ST_OK);
				end
				return 1'b1;
			end
			default: begin
				fr_phase = F_IDLE;
			end
		endcase
		return 1'b0;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic st, input bit typed = 1'b0,
			input res_t want = '0);
		res_t r;
		bit   has;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		do @(posedge clk); while (!s_tready);
		has = deframe_step(b, st, r);
		if (typed) begin
			pending.push_back(want);
		end else if (has) begin
			pending.push_back(r);
		end
		sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LimitW-1:0] v);
		wait_drained();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		buf_limit = v;
	endtask

	task automatic send_random_frame();
		logic [7:0] body [$];
		logic [7:0] len;
		logic [7:0] sum;
		logic [7:0] b;
		int         kind;
		int         pick;
		int         near;
		int         keep;
		kind = $urandom_range(99);
		if (kind >= 94) begin
			// noise, with the odd start mark
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(99) < 20);
			return;
		end
		pick = $urandom_range(99);
		near = int'(buf_limit) - 2 + int'($urandom_range(1));
		if (pick < 5) begin
			len = 8'($urandom_range(255));
		end else if (pick < 25 && buf_limit <= 40) begin
			len = 8'((near < 0) ? 0 : near);
		end else begin
			len = 8'($urandom_range(6));
		end
		sum = '0;
		body.push_back(PRE_BYTE);
		body.push_back(PRE_BYTE);
		body.push_back(START_BYTE);
		body.push_back(len);
		body.push_back(8'h00 - len);
		repeat (len) begin
			b = 8'($urandom);
			sum = sum + b;
			body.push_back(b);
		end
		body.push_back(8'h00 - sum);
		body.push_back(POST_BYTE);
		keep = body.size();
		if (kind < 14) begin
			body[$urandom_range(2)] ^= 8'($urandom_range(1, 255));
		end else if (kind < 22) begin
			body[4] ^= 8'($urandom_range(1, 255));
		end else if (kind < 32) begin
			body[keep-2] ^= 8'($urandom_range(1, 255));
		end else if (kind < 40) begin
			body[keep-1] ^= 8'($urandom_range(1, 255));
		end else if (kind < 45) begin
			body[keep-2] ^= 8'($urandom_range(1, 255));
			body[keep-1] ^= 8'($urandom_range(1, 255));
		end else if (kind < 53) begin
			// cut short; the next start mark drops it
			keep = $urandom_range(keep - 1);
		end
		send_byte(8'($urandom), 1'b1);
		for (int i = 0; i < keep; i++) begin
			send_byte(body[i], 1'b0);
		end
		if (kind >= 53 && kind < 60) begin
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR %0s: got 0x%0h, expected 0x%0h", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		m_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				report_mismatch("result item with none expected", {m_tuser, m_tdata}, 0);
			end else begin
				want = pending.pop_front();
				if (m_tdata[7:0] !== want.data_byte)
					report_mismatch("data_byte", m_tdata[7:0], want.data_byte);
				if (m_tuser[0] !== want.data_valid)
					report_mismatch("data_valid", m_tuser[0], want.data_valid);
				if (m_tlast !== want.frame_done)
					report_mismatch("frame_done", m_tlast, want.frame_done);
				if (m_tuser[3:1] !== want.frame_status)
					report_mismatch("frame_status", m_tuser[3:1], want.frame_status);
				if (m_tdata[15:8] !== want.frame_length)
					report_mismatch("frame_length", m_tdata[15:8], want.frame_length);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("nfc_reader_response_deframer_tb NOT OK");
			$finish;
		end
	end

	initial begin
		logic [LimitW-1:0] lim;
		bit                paused;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 37;
		recv_idle = 72;
		foreach (script[i]) begin
			send_byte(script[i].b, script[i].st, script[i].typed, script[i].want);
		end

		for (int ph = 0; ph < 6; ph++) begin
			send_idle = (ph < 2) ? 37 : (ph < 4) ? 72 : 0;
			recv_idle = (ph < 2) ? 72 : (ph < 4) ? 37 : 0;
			case (ph)
				0: lim = 9'd511;
				1: lim = 9'd0;
				2: lim = 9'd9;
				3: lim = LIMIT_RESET;
				4: lim = 9'($urandom_range(2, 40));
				default: lim = 9'd130;
			endcase
			write_limit(lim);
			sent = 0;
			paused = 1'b0;
			while (sent < 55) begin
				if (!paused && sent >= 25) begin
					// hold the sender until the output side has caught up
					wait_drained();
					paused = 1'b1;
				end
				send_random_frame();
			end
		end

		wait_drained();
		if (errors == 0) begin
			$display("nfc_reader_response_deframer_tb OK");
		end else begin
			$display("nfc_reader_response_deframer_tb NOT OK");
		end
		$finish;
	end

endmodule
